// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FRE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define FRE_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	`FRE_ASSERT(lbl, clk, rst_n, !(expr))
`else
`define FRE_ASSERT(lbl, clk, rst_n, prop)
`define FRE_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== rtl/core/fre_pkg.sv =====
package fre_pkg;

	localparam int FRAC_BITS = 16;

	localparam int TIME_W = 64;
	localparam int MEAN_W = 48;
	localparam int RATE_W = 32;
	localparam int CNT_W  = 32;
	localparam int GAIN_W = 17;
	localparam int WARM_W = 16;
	localparam int DT_W   = MEAN_W - FRAC_BITS;
	localparam int ALU_W  = 66;
	localparam int DIV_W  = MEAN_W + 1;
	localparam int ITER_W = 6;
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	localparam logic [TIME_W-1:0] RATE_NUM   = TIME_W'(64'd1000000 << (FRAC_BITS + 16));
	localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(65536);
	localparam logic [15:0]       ROUND_HALF = 16'h8000;

	localparam logic [GAIN_W-1:0] GAIN_RST   = GAIN_W'(32768);
	localparam logic [WARM_W-1:0] WARMUP_RST = WARM_W'(1);
	localparam logic              USE_FT_RST = 1'b0;

	typedef enum logic [1:0] {
		REG_GAIN   = 2'd0,
		REG_WARMUP = 2'd1,
		REG_USE_FT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] ema_gain;
		logic [WARM_W-1:0] warmup_frames;
		logic              use_frame_time;
	} cfg_t;

	typedef struct packed {
		logic [MEAN_W-1:0] mean_interval;
		logic [RATE_W-1:0] rate_hz;
		logic              rate_ok;
		logic              time_error;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DT,
		ST_MAG,
		ST_MAGN,
		ST_PREP,
		ST_MUL,
		ST_RND,
		ST_DIV,
		ST_CLAMP,
		ST_UPD,
		ST_COMMIT,
		ST_RATE0,
		ST_RCHK,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/core/fre_alu.sv =====
module fre_alu (
	input  logic [fre_pkg::ALU_W-1:0] a,
	input  logic [fre_pkg::ALU_W-1:0] b,
	input  logic                      sub,
	output logic [fre_pkg::ALU_W-1:0] y,
	output logic                      co
);
	import fre_pkg::*;

	logic [ALU_W-1:0] b_eff;

	assign b_eff = sub ? ~b : b;
	assign {co, y} = {1'b0, a} + {1'b0, b_eff} + (ALU_W + 1)'(sub);

endmodule

// ===== rtl/core/fre_cfg.sv =====
module fre_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fre_pkg::APB_AW-1:0] paddr,
	input  logic [fre_pkg::APB_DW-1:0] pwdata,
	output logic [fre_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output fre_pkg::cfg_t              cfg
);
	import fre_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ema_gain       <= GAIN_RST;
			cfg_q.warmup_frames  <= WARMUP_RST;
			cfg_q.use_frame_time <= USE_FT_RST;
		end else if (wr) begin
			unique case (idx)
				REG_GAIN:   cfg_q.ema_gain       <= pwdata[GAIN_W-1:0];
				REG_WARMUP: cfg_q.warmup_frames  <= pwdata[WARM_W-1:0];
				REG_USE_FT: cfg_q.use_frame_time <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_GAIN:   prdata = APB_DW'(cfg_q.ema_gain);
			REG_WARMUP: prdata = APB_DW'(cfg_q.warmup_frames);
			REG_USE_FT: prdata = APB_DW'(cfg_q.use_frame_time);
			default:    prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/fre_core.sv =====
module fre_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fre_pkg::cfg_t              cfg,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [fre_pkg::TIME_W-1:0] frame_time_us,
	input  logic                       frame_time_ok,
	input  logic [fre_pkg::TIME_W-1:0] system_time_us,
	output logic                       res_valid,
	input  logic                       res_ready,
	output fre_pkg::res_t              res
);
	import fre_pkg::*;

	state_t            state_q, state_d;
	logic [TIME_W-1:0] t_q, last_time_q;
	logic              err_q, last_ok_q, up_q, div_rate_q;
	logic [CNT_W-1:0]  count_q;
	logic [MEAN_W-1:0] avg_q, mag_q, rem_q, den_q;
	logic [ALU_W-1:0]  acc_q;
	logic [TIME_W-1:0] dsh_q, dsh_nxt;
	logic [GAIN_W-1:0] gsh_q, g_eff;
	logic [ITER_W-1:0] cnt_q;
	logic [RATE_W-1:0] rate_q;

	logic [ALU_W-1:0]  alu_a, alu_b, alu_y;
	logic              alu_sub, alu_co;

	logic              in_err, warm, dt_sat;
	logic [CNT_W-1:0]  cdiv;
	logic [DT_W-1:0]   dt_clip;
	logic [MEAN_W-1:0] x_val;

	fre_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.y   (alu_y),
		.co  (alu_co)
	);

	assign in_err  = cfg.use_frame_time & ~frame_time_ok;
	assign warm    = count_q <= CNT_W'(cfg.warmup_frames);
	assign cdiv    = (count_q == '0) ? CNT_W'(1) : count_q;
	assign g_eff   = cfg.ema_gain[GAIN_W-1] ? GAIN_ONE : cfg.ema_gain;
	assign dt_sat  = |alu_y[TIME_W-1:DT_W];
	assign dt_clip = !alu_co ? '0 : (dt_sat ? '1 : alu_y[DT_W-1:0]);
	assign x_val   = {dt_clip, {FRAC_BITS{1'b0}}};
	assign dsh_nxt = {dsh_q[TIME_W-2:0], alu_co};

	assign in_ready  = state_q == ST_IDLE;
	assign res_valid = state_q == ST_DONE;

	assign res.mean_interval = avg_q;
	assign res.rate_hz       = rate_q;
	assign res.rate_ok       = |count_q[CNT_W-1:1];
	assign res.time_error    = err_q;

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			ST_DT: begin
				alu_a   = ALU_W'(t_q);
				alu_b   = ALU_W'(last_time_q);
				alu_sub = 1'b1;
			end
			ST_MAG: begin
				alu_a   = ALU_W'(acc_q[MEAN_W-1:0]);
				alu_b   = ALU_W'(avg_q);
				alu_sub = 1'b1;
			end
			ST_MAGN: begin
				alu_a   = ALU_W'(avg_q);
				alu_b   = ALU_W'(acc_q[MEAN_W-1:0]);
				alu_sub = 1'b1;
			end
			ST_PREP: begin
				alu_a = ALU_W'(mag_q);
				alu_b = ALU_W'(cdiv[CNT_W-1:1]);
			end
			ST_MUL: begin
				alu_a = {acc_q[ALU_W-2:0], 1'b0};
				alu_b = gsh_q[GAIN_W-1] ? ALU_W'(mag_q) : '0;
			end
			ST_RND: begin
				alu_a = acc_q;
				alu_b = ALU_W'(ROUND_HALF);
			end
			ST_DIV: begin
				alu_a   = ALU_W'({rem_q, dsh_q[TIME_W-1]});
				alu_b   = ALU_W'(den_q);
				alu_sub = 1'b1;
			end
			ST_CLAMP: begin
				alu_a   = ALU_W'(mag_q);
				alu_b   = acc_q;
				alu_sub = 1'b1;
			end
			ST_UPD: begin
				alu_a   = ALU_W'(avg_q);
				alu_b   = ALU_W'(acc_q[MEAN_W-1:0]);
				alu_sub = ~up_q;
			end
			ST_RATE0: begin
				alu_a = ALU_W'(RATE_NUM);
				alu_b = ALU_W'(avg_q[MEAN_W-1:1]);
			end
			ST_RCHK: begin
				alu_a   = ALU_W'(dsh_q[TIME_W-1:32]);
				alu_b   = ALU_W'(avg_q);
				alu_sub = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					priority if (in_err) state_d = ST_RATE0;
					else if (last_ok_q) state_d = ST_DT;
					else state_d = ST_COMMIT;
				end
			end
			ST_DT:     state_d = ST_MAG;
			ST_MAG:    state_d = alu_co ? ST_PREP : ST_MAGN;
			ST_MAGN:   state_d = ST_PREP;
			ST_PREP:   state_d = warm ? ST_DIV : ST_MUL;
			ST_MUL:    state_d = (cnt_q == ITER_W'(1)) ? ST_RND : ST_MUL;
			ST_RND:    state_d = ST_CLAMP;
			ST_DIV: begin
				if (cnt_q == ITER_W'(1)) state_d = div_rate_q ? ST_DONE : ST_CLAMP;
			end
			ST_CLAMP:  state_d = ST_UPD;
			ST_UPD:    state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_RATE0;
			ST_RATE0:  state_d = (avg_q == '0) ? ST_DONE : ST_RCHK;
			ST_RCHK:   state_d = alu_co ? ST_DONE : ST_DIV;
			ST_DONE:   state_d = res_ready ? ST_IDLE : ST_DONE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_time_q <= '0;
			last_ok_q   <= 1'b0;
			count_q     <= '0;
			avg_q       <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_COMMIT) begin
				last_time_q <= t_q;
				last_ok_q   <= 1'b1;
				if (count_q != '1) count_q <= count_q + CNT_W'(1);
			end
			if (state_q == ST_UPD) avg_q <= alu_y[MEAN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					t_q   <= cfg.use_frame_time ? frame_time_us : system_time_us;
					err_q <= in_err;
				end
			end
			ST_DT: acc_q <= ALU_W'(x_val);
			ST_MAG: begin
				up_q <= alu_co;
				if (alu_co) mag_q <= alu_y[MEAN_W-1:0];
			end
			ST_MAGN: mag_q <= alu_y[MEAN_W-1:0];
			ST_PREP: begin
				if (warm) begin
					dsh_q      <= TIME_W'(alu_y[DIV_W-1:0]) << (TIME_W - DIV_W);
					rem_q      <= '0;
					den_q      <= MEAN_W'(cdiv);
					cnt_q      <= ITER_W'(DIV_W);
					div_rate_q <= 1'b0;
				end else begin
					acc_q <= '0;
					gsh_q <= g_eff;
					cnt_q <= ITER_W'(GAIN_W);
				end
			end
			ST_MUL: begin
				acc_q <= alu_y;
				gsh_q <= {gsh_q[GAIN_W-2:0], 1'b0};
				cnt_q <= cnt_q - ITER_W'(1);
			end
			ST_RND: acc_q <= ALU_W'(alu_y[ALU_W-1:16]);
			ST_DIV: begin
				rem_q <= alu_co ? alu_y[MEAN_W-1:0] : {rem_q[MEAN_W-2:0], dsh_q[TIME_W-1]};
				dsh_q <= dsh_nxt;
				cnt_q <= cnt_q - ITER_W'(1);
				if (cnt_q == ITER_W'(1)) begin
					if (div_rate_q) rate_q <= dsh_nxt[RATE_W-1:0];
					else acc_q <= ALU_W'(dsh_nxt[DIV_W-1:0]);
				end
			end
			ST_CLAMP: begin
				if (!alu_co) acc_q <= ALU_W'(mag_q);
			end
			ST_RATE0: begin
				dsh_q <= alu_y[TIME_W-1:0];
				if (avg_q == '0) rate_q <= '1;
			end
			ST_RCHK: begin
				if (alu_co) begin
					rate_q <= '1;
				end else begin
					rem_q      <= MEAN_W'(dsh_q[TIME_W-1:32]);
					dsh_q      <= {dsh_q[31:0], 32'b0};
					den_q      <= avg_q;
					cnt_q      <= ITER_W'(RATE_W);
					div_rate_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/frame_rate_ema_estimator.sv =====
// Channel  Dir  Handshake                Payload
// s_*      in   s_tvalid / s_tready      tdata: frame_time_us, system_time_us; tuser: frame_time_ok
// m_*      out  m_tvalid / m_tready      tdata: mean_interval, rate_hz; tuser: rate_ok, time_error
// apb      in   psel & penable & pwrite  ema_gain @0x0, warmup_frames @0x4, use_frame_time @0x8
//
// A beat runs 17 multiply steps in the EMA phase and 49 divide steps in warm-up, with an extra
// magnitude step when the interval is below the average. The rate division on the shared 66-bit
// adder follows and is skipped when the rate saturates or the average is still zero.
// A first frame goes straight to commit; a missing timestamp goes straight to the rate stage.
// Reset clears the averaging state and the registers to their defaults; no clearing pass.
// A finished result waits in the output register while the next beat is accepted.
`include "assert_macros.svh"

module frame_rate_ema_estimator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// [63:0] frame_time_us, [127:64] system_time_us
	input  logic [127:0]               s_tdata,
	// [0] frame_time_ok
	input  logic                       s_tuser,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// [47:0] mean_interval, [79:48] rate_hz
	output logic [79:0]                m_tdata,
	// [0] rate_ok, [1] time_error
	output logic [1:0]                 m_tuser,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fre_pkg::APB_AW-1:0] paddr,
	input  logic [fre_pkg::APB_DW-1:0] pwdata,
	output logic [fre_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import fre_pkg::*;

	cfg_t        cfg;
	res_t        res;
	logic        res_valid, res_ready;
	logic        m_tvalid_q;
	logic [79:0] m_tdata_q;
	logic [1:0]  m_tuser_q;

	fre_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fre_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.frame_time_us  (s_tdata[63:0]),
		.frame_time_ok  (s_tuser),
		.system_time_us (s_tdata[127:64]),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.res            (res)
	);

	assign res_ready = ~m_tvalid_q | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q <= {res.rate_hz, res.mean_interval};
			m_tuser_q <= {res.time_error, res.rate_ok};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`FRE_ASSERT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready |=> !s_tready)
	`FRE_ASSERT(a_res_held, clk, arst_n, res_valid && !res_ready |=> res_valid && $stable(res))
	`FRE_ASSERT(a_no_rate_before_interval, clk, arst_n, m_tvalid && !m_tuser[0] |-> m_tdata[79:48] == 32'hFFFFFFFF && m_tdata[47:0] == 48'h0)
	`FRE_ASSERT_NEVER(a_out_without_load, clk, arst_n, !$past(m_tvalid) && m_tvalid && !$past(res_valid))

endmodule
